// ===== hdl/tos_pkg.sv =====
// Shared types and constants for the tricycle odometry step block.
// Holds the controller states, the multiplier step codes, the command struct
// and the fixed CORDIC and scaling constants. No dependencies.
package tos_pkg;

  // Number of entries in the arctangent table, and the iteration index width.
  localparam int AtanLen = 24;
  localparam int IdxW    = $clog2(AtanLen);

  // Field widths of the stream payloads and the configuration port.
  localparam int AngleW    = 16;
  localparam int ForwardW  = 24;
  localparam int HeadingW  = 16;
  localparam int RadiusW   = 16;
  localparam int InvBaseW  = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  localparam int InDataW   = 32;
  localparam int OutDataW  = 40;

  // CORDIC working widths: x and y stay near one in Q30, z in 2^-32 turn.
  localparam int CordW = 33;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegWheelRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInvWheelBase = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [RadiusW-1:0]  WheelRadiusRst  = 16'd2560;
  localparam logic [InvBaseW-1:0] InvWheelBaseRst = 24'd167772;

  // Scaling constants: 2*pi in Q24, 32768/pi in Q16, CORDIC gain in Q30.
  localparam logic [31:0] TwoPiQ24    = 32'd105414357;
  localparam logic [31:0] BaPerRadQ16 = 32'd683565276;
  localparam logic signed [CordW-1:0] CordicGainQ30 = 33'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] AtanTurns [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StRotate,
    StMulP,
    StMulT,
    StMulF,
    StMulA,
    StMulB,
    StMulH,
    StPack
  } state_e;

  // Which product the shared multiplier forms in a cycle.
  typedef enum logic [2:0] {
    MulNone,
    MulDistRadius,
    MulTravel,
    MulForward,
    MulSine,
    MulInvBase,
    MulHeading
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            capture;
    logic            rot_en;
    logic [IdxW-1:0] rot_idx;
    mul_op_e         mul_op;
    logic            out_load;
  } ctrl_cmd_t;

endpackage

// ===== hdl/tos_ctrl.sv =====
// Controller state machine of the tricycle odometry step block.
// Sequences the CORDIC iterations, the shared multiplier and the result load.
// Depends on tos_pkg.
module tos_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_start_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tos_pkg::ctrl_cmd_t cmd_o
);

  // Iteration count, capped at the size of the arctangent table.
  localparam int NumIter = (CORDIC_STEPS > tos_pkg::AtanLen) ? tos_pkg::AtanLen
                                                             : CORDIC_STEPS;
  localparam logic [tos_pkg::IdxW-1:0] LastIter = tos_pkg::IdxW'(NumIter - 1);

  tos_pkg::state_e state_q, state_d;
  logic [tos_pkg::IdxW-1:0] iter_q, iter_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  assign in_ready_o  = (state_q == tos_pkg::StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // State, iteration counter and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tos_pkg::StIdle;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    out_valid_d    = out_valid_q;
    cmd_o.capture  = accept;
    cmd_o.rot_en   = 1'b0;
    cmd_o.rot_idx  = iter_q;
    cmd_o.mul_op   = tos_pkg::MulNone;
    cmd_o.out_load = 1'b0;

    // The receiver taking the pending result frees the output register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tos_pkg::StIdle: begin
        iter_d = '0;
        if (accept && !in_start_i) begin
          state_d = tos_pkg::StRotate;
        end
      end
      tos_pkg::StRotate: begin
        cmd_o.rot_en = 1'b1;
        iter_d       = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          state_d = tos_pkg::StMulP;
        end
      end
      tos_pkg::StMulP: begin
        cmd_o.mul_op = tos_pkg::MulDistRadius;
        state_d      = tos_pkg::StMulT;
      end
      tos_pkg::StMulT: begin
        cmd_o.mul_op = tos_pkg::MulTravel;
        state_d      = tos_pkg::StMulF;
      end
      tos_pkg::StMulF: begin
        cmd_o.mul_op = tos_pkg::MulForward;
        state_d      = tos_pkg::StMulA;
      end
      tos_pkg::StMulA: begin
        cmd_o.mul_op = tos_pkg::MulSine;
        state_d      = tos_pkg::StMulB;
      end
      tos_pkg::StMulB: begin
        cmd_o.mul_op = tos_pkg::MulInvBase;
        state_d      = tos_pkg::StMulH;
      end
      tos_pkg::StMulH: begin
        cmd_o.mul_op = tos_pkg::MulHeading;
        state_d      = tos_pkg::StPack;
      end
      tos_pkg::StPack: begin
        // Wait here until the output register can take the result.
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tos_pkg::StIdle;
        end
      end
      default: begin
        state_d = tos_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== hdl/tos_datapath.sv =====
// Datapath of the tricycle odometry step block: configuration registers,
// previous wheel angle, CORDIC rotator, shared multiplier and output packing.
// Depends on tos_pkg.
module tos_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tos_pkg::ctrl_cmd_t                cmd_i,
  input  logic [tos_pkg::AngleW-1:0]        steer_angle_i,
  input  logic [tos_pkg::AngleW-1:0]        wheel_angle_i,
  input  logic                              cfg_we_i,
  input  logic [tos_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tos_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic [tos_pkg::ForwardW-1:0]      forward_step_o,
  output logic [tos_pkg::HeadingW-1:0]      heading_step_o,
  output logic                              saturated_o
);

  localparam int CW = tos_pkg::CordW;

  // Configuration and persistent state.
  logic [tos_pkg::RadiusW-1:0]  radius_q;
  logic [tos_pkg::InvBaseW-1:0] inv_base_q;
  logic [tos_pkg::AngleW-1:0]   prev_q;

  // Per-item working registers.
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 flip_q;
  logic                 dneg_q;
  logic [15:0]          dmag_q;
  logic [31:0]          p_q;
  logic [26:0]          t_q;
  logic [20:0]          f_q;
  logic [27:0]          a_q;
  logic [27:0]          b_q;
  logic [26:0]          h_q;

  // Output register.
  logic [tos_pkg::ForwardW-1:0] fwd_q;
  logic [tos_pkg::HeadingW-1:0] head_q;
  logic                         sat_q;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= tos_pkg::WheelRadiusRst;
      inv_base_q <= tos_pkg::InvWheelBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tos_pkg::RegWheelRadius:  radius_q   <= cfg_data_i[tos_pkg::RadiusW-1:0];
        tos_pkg::RegInvWheelBase: inv_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Every accepted item, start or not, becomes the new previous wheel angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.capture) begin
      prev_q <= wheel_angle_i;
    end
  end

  // Wheel angle difference as sign and magnitude.
  logic signed [16:0] diff;
  logic signed [16:0] diff_abs;
  assign diff     = 17'(signed'(wheel_angle_i)) - 17'(signed'(prev_q));
  assign diff_abs = diff[16] ? -diff : diff;

  // Steer angle folded into the right half plane.
  logic [31:0] z_turn;
  logic        flip;
  assign z_turn = {steer_angle_i, 16'b0};
  assign flip   = z_turn[31] ^ z_turn[30];

  // One CORDIC iteration with floor shifts.
  logic signed [CW-1:0] x_sh, y_sh, atan_v;
  logic                 z_pos;
  assign x_sh   = x_q >>> cmd_i.rot_idx;
  assign y_sh   = y_q >>> cmd_i.rot_idx;
  assign atan_v = signed'({1'b0, tos_pkg::AtanTurns[cmd_i.rot_idx]});
  assign z_pos  = !z_q[CW-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= tos_pkg::CordicGainQ30;
      y_q    <= '0;
      z_q    <= CW'(signed'({z_turn[31] ^ flip, z_turn[30:0]}));
      flip_q <= flip;
      dneg_q <= diff[16];
      dmag_q <= diff_abs[15:0];
    end else if (cmd_i.rot_en) begin
      if (z_pos) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_v;
      end
    end
  end

  // Cosine and sine as sign and magnitude, undoing the half-turn fold.
  logic        cneg, sneg;
  logic [30:0] cmag, smag;
  logic signed [CW-1:0] x_abs, y_abs;
  assign x_abs = x_q[CW-1] ? -x_q : x_q;
  assign y_abs = y_q[CW-1] ? -y_q : y_q;
  assign cmag  = x_abs[30:0];
  assign smag  = y_abs[30:0];
  assign cneg  = flip_q ? (!x_q[CW-1] && (x_q != '0)) : x_q[CW-1];
  assign sneg  = flip_q ? (!y_q[CW-1] && (y_q != '0)) : y_q[CW-1];

  // Shared multiplier: operand selection and the rounded products.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, f_sum, h_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      tos_pkg::MulDistRadius: begin
        mul_a = {16'b0, dmag_q};
        mul_b = {16'b0, radius_q};
      end
      tos_pkg::MulTravel: begin
        mul_a = p_q;
        mul_b = tos_pkg::TwoPiQ24;
      end
      tos_pkg::MulForward: begin
        mul_a = {5'b0, t_q};
        mul_b = {1'b0, cmag};
      end
      tos_pkg::MulSine: begin
        mul_a = {5'b0, t_q};
        mul_b = {1'b0, smag};
      end
      tos_pkg::MulInvBase: begin
        mul_a = {4'b0, a_q};
        mul_b = {8'b0, inv_base_q};
      end
      tos_pkg::MulHeading: begin
        mul_a = {4'b0, b_q};
        mul_b = tos_pkg::BaPerRadQ16;
      end
      default: ;
    endcase
  end

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign f_sum = prod + (64'd1 << 37);
  assign h_sum = prod + (64'd1 << 31);

  // Product registers, one per step of the chain.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.mul_op)
      tos_pkg::MulDistRadius: p_q <= prod[31:0];
      tos_pkg::MulTravel:     t_q <= prod[58:32];
      tos_pkg::MulForward:    f_q <= f_sum[58:38];
      tos_pkg::MulSine:       a_q <= prod[57:30];
      tos_pkg::MulInvBase:    b_q <= prod[51:24];
      tos_pkg::MulHeading:    h_q <= h_sum[58:32];
      default: ;
    endcase
  end

  // Signed packing with saturation.
  logic        fneg, hneg, fsat, hsat;
  logic [24:0] fmag;
  logic [26:0] hmag;
  logic [tos_pkg::ForwardW-1:0] fwd_d;
  logic [tos_pkg::HeadingW-1:0] head_d;

  always_comb begin
    fneg = dneg_q ^ cneg;
    hneg = dneg_q ^ sneg;
    fmag = {4'b0, f_q};
    hmag = h_q;
    fsat = 1'b0;
    hsat = 1'b0;
    if (fneg) begin
      if (fmag > 25'd8388608) begin
        fmag = 25'd8388608;
        fsat = 1'b1;
      end
    end else if (fmag > 25'd8388607) begin
      fmag = 25'd8388607;
      fsat = 1'b1;
    end
    if (hneg) begin
      if (hmag > 27'd32768) begin
        hmag = 27'd32768;
        hsat = 1'b1;
      end
    end else if (hmag > 27'd32767) begin
      hmag = 27'd32767;
      hsat = 1'b1;
    end
    fwd_d  = fneg ? (24'd0 - fmag[23:0]) : fmag[23:0];
    head_d = hneg ? (16'd0 - hmag[15:0]) : hmag[15:0];
  end

  // Output register; its valid flag lives in the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      fwd_q  <= fwd_d;
      head_q <= head_d;
      sat_q  <= fsat || hsat;
    end
  end

  assign forward_step_o = fwd_q;
  assign heading_step_o = head_q;
  assign saturated_o    = sat_q;

endmodule

// ===== hdl/tricycle_odometry_step_top.sv =====
// Top level of the tricycle odometry step block.
// Joins the controller and the datapath and maps the stream and config ports.
// Depends on tos_pkg, tos_ctrl and tos_datapath.
//
// Usage: each request on the slave stream carries a steer angle and a drive
// wheel angle (binary angles, a full turn is 65536) and a start flag in tuser.
// A start request only stores the wheel angle and gives no result. Any other
// request gives one result on the master stream: the forward step (signed
// Q15.8 cm) and the heading step (binary angle), with a saturation flag in
// tuser. The config channel writes wheel_radius (index 0) and inv_wheel_base
// (index 1) and is always ready; write only while the block is idle.
// A step request runs through the one shared CORDIC iteration stage, then six
// passes through the single shared 32x32 multiplier and one packing step, and
// then loads its result into the output register. The next request is taken
// in the cycle after the result loads, so no step request is taken before the
// last one is through. A start request leaves the block idle and ready. After
// reset the registers hold their defaults and the stored wheel angle is zero.
// If the receiver stalls, the result waits in the output register, one more
// request may be accepted and computed, and that one waits in the packing step
// until the register frees.
module tricycle_odometry_step_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Slave stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: steer_angle [15:0], wheel_angle [31:16].
  input  logic [tos_pkg::InDataW-1:0]      s_axis_tdata_i,
  // tuser: start_req [0].
  input  logic                             s_axis_tuser_i,
  // Master stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: forward_step [23:0], heading_step [39:24].
  output logic [tos_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // tuser: saturated [0].
  output logic                             m_axis_tuser_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tos_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tos_pkg::CfgDataW-1:0]     cfg_data_i
);

  tos_pkg::ctrl_cmd_t cmd;
  logic [tos_pkg::ForwardW-1:0] forward_step;
  logic [tos_pkg::HeadingW-1:0] heading_step;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  tos_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_start_i (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd)
  );

  tos_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .steer_angle_i (s_axis_tdata_i[15:0]),
    .wheel_angle_i (s_axis_tdata_i[31:16]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .forward_step_o(forward_step),
    .heading_step_o(heading_step),
    .saturated_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {heading_step, forward_step};

endmodule

// ===== hdl/tos_port_checker.sv =====
// Port-level checks for the tricycle odometry step block, bound to the top.
// Sees the top level's ports only. Depends on tos_pkg and the top level.
module tos_port_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [tos_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A step request occupies the block, so the next cycle is not ready.
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("ready stayed high after a step request");

  // A start request leaves the block ready in the next cycle.
  a_start_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i) |=> s_axis_tready_o)
    else $error("start request did not return to ready");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

  // The saturation flag only comes with an output at a clip limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[39:24] == 16'h7FFF || m_axis_tdata_o[39:24] == 16'h8000 ||
       m_axis_tdata_o[23:0] == 24'h7FFFFF || m_axis_tdata_o[23:0] == 24'h800000))
    else $error("saturated set without a clipped output");

endmodule

bind tricycle_odometry_step_top tos_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the tricycle odometry step block.
// Drives step and start requests on the slave stream, predicts each result in
// fixed point and checks it on the master stream. Depends on tos_pkg and the top level.
`timescale 1ns / 1ps

module tb;
  import tos_pkg::*;

  localparam int CordicSteps = 16;
  localparam int Latency     = CordicSteps + 8;
  localparam int HoldCycles  = 300;
  localparam int RandItems   = 500;
  localparam int CycleLimit  = 300000;

  // One result of the block: forward step, heading step, saturation flag.
  typedef struct packed {
    logic [ForwardW-1:0] fwd;
    logic [HeadingW-1:0] hdg;
    logic                sat;
  } step_t;

  typedef enum {RowStep, RowStart, RowCfg} row_kind_e;

  // One line of the directed plan; want is used only where typed is set.
  typedef struct {
    row_kind_e             kind;
    logic [AngleW-1:0]     steer;
    logic [AngleW-1:0]     wheel;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    logic                  typed;
    step_t                 want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Predictor state and its copy of the configuration.
  logic [AngleW-1:0] last_wheel = '0;
  longint unsigned   radius_q8 = WheelRadiusRst;
  longint unsigned   inv_base_q24 = InvWheelBaseRst;

  step_t steps_due[$];
  row_t  plan[$];
  int    mismatch_cnt = 0;
  bit    idle_on = 1'b1;
  bit    hold_ask = 1'b0;

  logic [AngleW-1:0] angle_edges [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                         16'h7FFF, 16'hFFFF};

  tricycle_odometry_step_top #(
    .CORDIC_STEPS(CordicSteps)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rotation-mode CORDIC on a binary angle; returns cosine and sine in Q30.
  function automatic void cordic_sin_cos(input logic [AngleW-1:0] steer,
                                         output longint c, output longint s);
    logic [31:0] zu;
    logic        flip;
    longint      x, y, z, nx, at;
    int          n;
    zu = {steer, 16'h0000};
    // Second and third quadrant are turned by pi and the results negated.
    flip = (zu[31:30] == 2'b01) || (zu[31:30] == 2'b10);
    if (flip) zu = zu - 32'h8000_0000;
    z = {{32{zu[31]}}, zu};
    x = CordicGainQ30;
    y = 0;
    n = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
    for (int i = 0; i < n; i++) begin
      at = AtanTurns[i];
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - at;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + at;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Forward and heading step for one request against the stored wheel angle.
  function automatic step_t calc_step(input logic [AngleW-1:0] steer,
                                      input logic [AngleW-1:0] wheel);
    step_t           r;
    longint          w, p, d, c, s;
    longint unsigned dmag, t, cmag, smag, fmag, a, b, hmag;
    logic            dneg, fneg, hneg;
    w = $signed(wheel);
    p = $signed(last_wheel);
    d = w - p;
    dneg = (d < 0);
    dmag = dneg ? -d : d;
    t = (dmag * radius_q8 * TwoPiQ24) >> 32;
    cordic_sin_cos(steer, c, s);
    cmag = (c < 0) ? -c : c;
    smag = (s < 0) ? -s : s;
    fmag = (t * cmag + (64'd1 << 37)) >> 38;
    a = (t * smag) >> 30;
    b = (a * inv_base_q24) >> 24;
    hmag = (b * BaPerRadQ16 + (64'd1 << 31)) >> 32;
    fneg = dneg != (c < 0);
    hneg = dneg != (s < 0);
    r.sat = 1'b0;
    // Clip each magnitude to the signed range of its field.
    if (fmag > (fneg ? 64'd8388608 : 64'd8388607)) begin
      fmag = fneg ? 64'd8388608 : 64'd8388607;
      r.sat = 1'b1;
    end
    if (hmag > (hneg ? 64'd32768 : 64'd32767)) begin
      hmag = hneg ? 64'd32768 : 64'd32767;
      r.sat = 1'b1;
    end
    if (fneg) fmag = -fmag;
    if (hneg) hmag = -hmag;
    r.fwd = fmag[ForwardW-1:0];
    r.hdg = hmag[HeadingW-1:0];
    return r;
  endfunction

  function automatic row_t step_row(input logic [15:0] steer, input logic [15:0] wheel);
    row_t r;
    r = '{kind: RowStep, steer: steer, wheel: wheel, reg_idx: '0, reg_val: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  // A step whose result is all zeros: no wheel motion, or a zero register.
  function automatic row_t zero_row(input logic [15:0] steer, input logic [15:0] wheel);
    row_t r;
    r = step_row(steer, wheel);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic row_t start_row(input logic [15:0] steer, input logic [15:0] wheel);
    row_t r;
    r = step_row(steer, wheel);
    r.kind = RowStart;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
    row_t r;
    r = step_row('0, '0);
    r.kind = RowCfg;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Register value spread over the whole range, with the extremes and zero.
  function automatic logic [CfgDataW-1:0] pick_reg(input int width);
    logic [CfgDataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 24'd1;
      1: v = '1;
      2: v = '0;
      default: v = 24'($urandom >> $urandom_range(0, 31));
    endcase
    return v & ((24'd1 << width) - 24'd1);
  endfunction

  task automatic compare_field(input string what, input logic [23:0] want_v,
                               input logic [23:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // Present one request, wait for its handshake and record what it should give.
  task automatic offer(input logic st, input logic [15:0] steer, input logic [15:0] wheel,
                       input logic typed, input step_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {wheel, steer};
    s_axis_tuser_i  <= st;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (!st) steps_due.push_back(typed ? want : calc_step(steer, wheel));
    last_wheel = wheel;
  endtask

  // Stop offering and wait until the block has delivered everything.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegWheelRadius) radius_q8 = val[RadiusW-1:0];
    else if (idx == RegInvWheelBase) inv_base_q24 = val;
    @(posedge clk_i);
  endtask

  // Random request: small wheel motion half the time, else jumps and quadrant edges.
  task automatic rand_item();
    logic        st;
    logic [15:0] steer, wheel;
    st = ($urandom_range(0, 7) == 0);
    steer = ($urandom_range(0, 5) == 0) ? angle_edges[$urandom_range(0, 5)] : 16'($urandom);
    case ($urandom_range(0, 5))
      0, 1: wheel = 16'($urandom);
      2: wheel = angle_edges[$urandom_range(0, 5)];
      default: wheel = last_wheel + 16'($urandom_range(0, 2047)) - 16'd1024;
    endcase
    offer(st, steer, wheel, 1'b0, '0);
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    step_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.fwd = m_axis_tdata_o[ForwardW-1:0];
      got.hdg = m_axis_tdata_o[ForwardW+HeadingW-1:ForwardW];
      got.sat = m_axis_tuser_o;
      if (steps_due.size() == 0) begin
        $display("%0t: result with nothing pending, actual fwd %h hdg %h sat %b",
                 $time, got.fwd, got.hdg, got.sat);
        mismatch_cnt++;
      end else begin
        want = steps_due.pop_front();
        compare_field("forward_step", want.fwd, got.fwd);
        compare_field("heading_step", 24'(want.hdg), 24'(got.hdg));
        compare_field("saturated", 24'(want.sat), 24'(got.sat));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off when asked.
  initial begin : sink_ready
    int unsigned gap;
    gap = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_ask) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_ask = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        gap = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tricycle_odometry_step_top verification failed");
    $finish;
  end

  // Stimulus: directed plan, then random phases with fresh register settings.
  initial begin : stimulus
    int rand_cnt, phase;
    rand_cnt = 0;
    phase = 0;

    // Directed plan, starting from the reset defaults.
    plan.push_back(zero_row(16'h0000, 16'h0000));
    plan.push_back(step_row(16'h7FFF, 16'h7FFF));
    plan.push_back(step_row(16'h8000, 16'h8000));
    plan.push_back(start_row(16'h7FFF, 16'h8000));
    plan.push_back(step_row(16'h4000, 16'h7FFF));
    // Largest radius and reciprocal wheelbase drive the heading into saturation.
    plan.push_back(cfg_row(RegWheelRadius, 24'h00FFFF));
    plan.push_back(cfg_row(RegInvWheelBase, 24'hFFFFFF));
    plan.push_back(start_row(16'hFFFF, 16'h8000));
    plan.push_back(step_row(16'h4000, 16'h7FFF));
    plan.push_back(step_row(16'hC000, 16'h8000));
    plan.push_back(step_row(16'h4000, 16'h7FFF));
    plan.push_back(step_row(16'h4000, 16'h8000));
    plan.push_back(zero_row(16'h1234, 16'h8000));
    plan.push_back(step_row(16'h2000, 16'h0000));
    // Zero registers give zero steps whatever the motion.
    plan.push_back(cfg_row(RegWheelRadius, 24'h000000));
    plan.push_back(cfg_row(RegInvWheelBase, 24'h000000));
    plan.push_back(zero_row(16'h4000, 16'h7FFF));
    plan.push_back(cfg_row(RegWheelRadius, 24'h000001));
    plan.push_back(cfg_row(RegInvWheelBase, 24'h000001));
    plan.push_back(step_row(16'h6000, 16'h8000));
    plan.push_back(step_row(16'hA000, 16'h0001));
    plan.push_back(step_row(16'hE000, 16'hFFFF));
    plan.push_back(start_row(16'h0000, 16'h5555));
    plan.push_back(start_row(16'hFFFF, 16'hAAAA));
    plan.push_back(step_row(16'h5555, 16'h2AAA));
    plan.push_back(step_row(16'hAAAA, 16'hD555));
    plan.push_back(step_row(16'h8000, 16'hD556));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      case (plan[k].kind)
        RowCfg: begin
          settle();
          write_reg(plan[k].reg_idx, plan[k].reg_val);
        end
        RowStart: offer(1'b1, plan[k].steer, plan[k].wheel, 1'b0, '0);
        default: offer(1'b0, plan[k].steer, plan[k].wheel, plan[k].typed, plan[k].want);
      endcase
    end

    // Random phases; the second one holds the receiver off while requests keep coming.
    while (rand_cnt < RandItems) begin
      settle();
      write_reg(RegWheelRadius, pick_reg(RadiusW));
      write_reg(RegInvWheelBase, pick_reg(InvBaseW));
      if (rand_cnt >= RandItems * 4 / 5) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        idle_on = 1'b0;
        hold_ask = 1'b1;
      end
      repeat ($urandom_range(30, 70)) begin
        rand_item();
        rand_cnt++;
      end
      phase++;
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("tricycle_odometry_step_top verification clean");
    end else begin
      $display("tricycle_odometry_step_top verification failed");
    end
    $finish;
  end

endmodule
